/* design/one_wire_rom_search_unit_assert.svh */
// Assertion macros used by the checker of the 1-Wire ROM search unit.
// Needs clk and rst_n in the scope where a macro is used, and out_valid and out_ready for OSR_ASSERT_HOLD.
`ifndef ONE_WIRE_ROM_SEARCH_UNIT_ASSERT_SVH
`define ONE_WIRE_ROM_SEARCH_UNIT_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define OSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a signal holds while a result waits on a stalled receiver.
`define OSR_ASSERT_HOLD(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        out_valid && !out_ready |=> $stable(sig)) else $error(msg);

`endif

/* design/osr_pkg.sv */
// Types and constants of the 1-Wire ROM search unit.
// Used by every module of the block; depends on nothing.
package osr_pkg;

    localparam int ROM_WIDTH = 64;
    localparam int POS_WIDTH = 7;
    localparam int FAM_WIDTH = 4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PAIR  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_STARTED     = 3'd0;
    localparam logic [2:0] ST_BIT_DONE    = 3'd1;
    localparam logic [2:0] ST_FOUND       = 3'd2;
    localparam logic [2:0] ST_NO_PRESENCE = 3'd3;
    localparam logic [2:0] ST_NO_MORE     = 3'd4;
    localparam logic [2:0] ST_FAILED      = 3'd5;
    localparam logic [2:0] ST_IGNORED     = 3'd6;

    localparam logic [POS_WIDTH-1:0] END_POSITION = 7'd65;
    localparam logic [POS_WIDTH-1:0] FAMILY_LIMIT = 7'd9;
    localparam logic [POS_WIDTH-1:0] FIRST_POS    = 7'd1;
    localparam logic [FAM_WIDTH-1:0] FAMILY_MAX   = 4'd8;

    typedef struct packed {
        logic [1:0] opcode;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } osr_req_t;

    typedef struct packed {
        logic [ROM_WIDTH-1:0] rom_bits;
        logic [POS_WIDTH-1:0] last_branch;
        logic [FAM_WIDTH-1:0] last_family_branch;
        logic                 final_device;
        logic [POS_WIDTH-1:0] bit_position;
        logic [POS_WIDTH-1:0] zero_branch;
        logic                 searching;
    } osr_state_t;

    typedef struct packed {
        logic [2:0]           status;
        logic                 write_bit;
        logic [ROM_WIDTH-1:0] rom_code;
        logic                 last_device;
        logic [FAM_WIDTH-1:0] family_discrepancy;
    } osr_rsp_t;

endpackage

/* design/osr_in_reg.sv */
// Input register of the 1-Wire ROM search unit: captures one request.
// Depends on osr_pkg.
module osr_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  osr_pkg::osr_req_t req_in,
    input  logic              advance,
    output logic              req_valid,
    output osr_pkg::osr_req_t req
);
    import osr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    osr_req_t req_reg;

    // The stage takes a new request whenever it is empty or its current one moves on this cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_in;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

/* design/osr_decide.sv */
// Decision logic of the 1-Wire ROM search: next search state and result
// for one request. Purely combinational; depends on osr_pkg.
module osr_decide (
    input  osr_pkg::osr_req_t   req,
    input  osr_pkg::osr_state_t cur,
    output osr_pkg::osr_state_t nxt,
    output osr_pkg::osr_rsp_t   rsp
);
    import osr_pkg::*;

    logic [POS_WIDTH-1:0] pos_inc;
    logic [5:0]           idx;
    logic                 dir;
    logic [2:0]           status;
    logic                 wbit;

    always_comb
    begin
        nxt     = cur;
        status  = ST_IGNORED;
        wbit    = 1'b0;
        dir     = 1'b0;
        pos_inc = cur.bit_position + FIRST_POS;
        idx     = cur.bit_position[5:0] - 6'd1;

        case (req.opcode)
            OP_START:
            begin
                nxt.searching    = 1'b0;
                nxt.bit_position = FIRST_POS;
                nxt.zero_branch  = '0;
                if (cur.final_device)
                begin
                    nxt.last_branch        = '0;
                    nxt.last_family_branch = '0;
                    nxt.final_device       = 1'b0;
                    status                 = ST_NO_MORE;
                end
                else if (!req.presence)
                begin
                    nxt.last_branch        = '0;
                    nxt.last_family_branch = '0;
                    nxt.final_device       = 1'b0;
                    nxt.rom_bits           = '0;
                    status                 = ST_NO_PRESENCE;
                end
                else
                begin
                    nxt.searching = 1'b1;
                    status        = ST_STARTED;
                end
            end
            OP_PAIR:
            begin
                if (cur.searching)
                begin
                    if (req.id_bit && req.complement_bit)
                    begin
                        nxt.last_branch        = '0;
                        nxt.last_family_branch = '0;
                        nxt.final_device       = 1'b0;
                        nxt.searching          = 1'b0;
                        nxt.bit_position       = FIRST_POS;
                        nxt.zero_branch        = '0;
                        status                 = ST_FAILED;
                    end
                    else
                    begin
                        // Devices agree on this bit: take their bit. Devices disagree: follow the previous path
                        // below the last discrepancy, take one at it, zero above.
                        if (req.id_bit != req.complement_bit)
                        begin
                            dir = req.id_bit;
                        end
                        else if (cur.bit_position < cur.last_branch)
                        begin
                            dir = cur.rom_bits[idx];
                        end
                        else
                        begin
                            dir = (cur.bit_position == cur.last_branch);
                        end
                        if ((req.id_bit == req.complement_bit) && !dir)
                        begin
                            nxt.zero_branch = cur.bit_position;
                            if (cur.bit_position < FAMILY_LIMIT)
                            begin
                                nxt.last_family_branch = cur.bit_position[FAM_WIDTH-1:0];
                            end
                        end
                        nxt.rom_bits[idx] = dir;
                        wbit              = dir;
                        if (pos_inc >= END_POSITION)
                        begin
                            nxt.last_branch = nxt.zero_branch;
                            if (nxt.zero_branch == '0)
                            begin
                                nxt.final_device = 1'b1;
                            end
                            if (nxt.rom_bits[7:0] == 8'd0)
                            begin
                                nxt.last_branch        = '0;
                                nxt.last_family_branch = '0;
                                nxt.final_device       = 1'b0;
                                status                 = ST_FAILED;
                                wbit                   = 1'b0;
                            end
                            else
                            begin
                                status = ST_FOUND;
                            end
                            nxt.searching    = 1'b0;
                            nxt.bit_position = FIRST_POS;
                            nxt.zero_branch  = '0;
                        end
                        else
                        begin
                            nxt.bit_position = pos_inc;
                            status           = ST_BIT_DONE;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                nxt.rom_bits           = '0;
                nxt.last_branch        = '0;
                nxt.last_family_branch = '0;
                nxt.final_device       = 1'b0;
                nxt.searching          = 1'b0;
                nxt.bit_position       = FIRST_POS;
                nxt.zero_branch        = '0;
                status                 = ST_IGNORED;
            end
            default:
            begin
                status = ST_IGNORED;
            end
        endcase

        rsp.status             = status;
        rsp.write_bit          = wbit;
        rsp.rom_code           = nxt.rom_bits;
        rsp.last_device        = nxt.final_device;
        rsp.family_discrepancy = nxt.last_family_branch;
    end

endmodule

/* design/one_wire_rom_search_unit.sv */
// 1-Wire ROM search unit: decides the direction bit of each step of a
// search ROM pass and reports the ROM code of each device found.
// Depends on osr_pkg, osr_in_reg and osr_decide.
//
// Input channel (in_valid/in_ready): one request per handshake. A start
// request carries the presence answer of the bus reset, a bit-pair request
// carries the id bit and its complement, a clear request drops all search
// state. Output channel (out_valid/out_ready): exactly one result per
// request, in order: status, direction bit to write, current ROM code,
// last-device flag and family discrepancy.
// A request taken in goes into the input register and, once the result
// register is free or being emptied, on into the result register; the
// decision logic works out the result register and the search state,
// written together. Throughput: one request per cycle while out_ready stays
// high and the result register can drain. A result waiting in the output
// register does not stop the next request from entering the input register;
// only when both are full and out_ready is low does in_ready fall.
// Reset clears the search state (ROM code, discrepancies, last-device flag,
// pass in progress) and empties both registers.
module one_wire_rom_search_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic                          presence,
    input  logic                          id_bit,
    input  logic                          complement_bit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic                          write_bit,
    output logic [osr_pkg::ROM_WIDTH-1:0] rom_code,
    output logic                          last_device,
    output logic [osr_pkg::FAM_WIDTH-1:0] family_discrepancy
);
    import osr_pkg::*;

    osr_req_t   req_in;
    osr_req_t   req;
    logic       req_valid;
    logic       advance;
    osr_state_t state_reg;
    osr_state_t state_next;
    osr_rsp_t   rsp_next;
    osr_rsp_t   rsp_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign req_in.opcode         = opcode;
    assign req_in.presence       = presence;
    assign req_in.id_bit         = id_bit;
    assign req_in.complement_bit = complement_bit;

    // A request is decided when the result register is free or being emptied.
    assign advance        = req_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    osr_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_in    (req_in),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    osr_decide u_decide (
        .req (req),
        .cur (state_reg),
        .nxt (state_next),
        .rsp (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.rom_bits           <= '0;
            state_reg.last_branch        <= '0;
            state_reg.last_family_branch <= '0;
            state_reg.final_device       <= 1'b0;
            state_reg.bit_position       <= FIRST_POS;
            state_reg.zero_branch        <= '0;
            state_reg.searching          <= 1'b0;
            out_valid_reg                <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = rsp_reg.status;
    assign write_bit          = rsp_reg.write_bit;
    assign rom_code           = rsp_reg.rom_code;
    assign last_device        = rsp_reg.last_device;
    assign family_discrepancy = rsp_reg.family_discrepancy;

endmodule

/* design/osr_checker.sv */
// Port-level checker of the 1-Wire ROM search unit, bound to the top level.
// Depends on osr_pkg and one_wire_rom_search_unit_assert.svh.
`include "one_wire_rom_search_unit_assert.svh"

module osr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [2:0]                    status,
    input logic                          write_bit,
    input logic [osr_pkg::ROM_WIDTH-1:0] rom_code,
    input logic [osr_pkg::FAM_WIDTH-1:0] family_discrepancy
);
    import osr_pkg::*;

    `OSR_ASSERT(a_out_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `OSR_ASSERT_HOLD(a_rom_code_holds, rom_code, "ROM code changed while stalled")
    `OSR_ASSERT(a_write_bit_status, out_valid && write_bit |-> (status == ST_BIT_DONE || status == ST_FOUND), "write bit set on a result without a direction")
    `OSR_ASSERT(a_found_family, out_valid && status == ST_FOUND |-> rom_code[7:0] != 8'd0, "device found with a zero family byte")
    `OSR_ASSERT(a_family_range, out_valid |-> family_discrepancy <= FAMILY_MAX, "family discrepancy beyond the family byte")

endmodule

bind one_wire_rom_search_unit osr_checker u_osr_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of one_wire_rom_search_unit: walks simulated 1-Wire buses through
// whole ROM searches, mixed with noise, and checks every result against a local predictor.
// Depends on osr_pkg and the RTL of one_wire_rom_search_unit; nothing else.

module tb_top;
    import osr_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         TOTAL_ITEMS  = 1850;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_DEVICES  = 6;

    // Tracks the search state of the unit and holds the results still owed by it.
    class search_scoreboard;
        logic [ROM_WIDTH-1:0] rom_image;
        logic [POS_WIDTH-1:0] prev_branch;
        logic [FAM_WIDTH-1:0] family_branch;
        logic                 last_found;
        logic [POS_WIDTH-1:0] cur_pos;
        logic [POS_WIDTH-1:0] new_branch;
        logic                 in_pass;
        osr_rsp_t             owed_results[$];
        int                   errors;

        function new();
            rom_image     = '0;
            prev_branch   = '0;
            family_branch = '0;
            last_found    = 1'b0;
            errors        = 0;
            close_pass();
        endfunction

        function void drop_branches();
            prev_branch   = '0;
            family_branch = '0;
            last_found    = 1'b0;
        endfunction

        function void close_pass();
            in_pass    = 1'b0;
            cur_pos    = FIRST_POS;
            new_branch = '0;
        endfunction

        // Applies one accepted request to the tracked state and queues the result it owes.
        function osr_rsp_t note_request(logic [1:0] op, logic pres, logic idb, logic cmpb);
            osr_rsp_t res;
            logic [2:0] st;
            logic dir;
            int idx;
            st  = ST_IGNORED;
            dir = 1'b0;
            case (op)
                OP_START:
                begin
                    if (last_found)
                    begin
                        drop_branches();
                        st = ST_NO_MORE;
                    end
                    else if (!pres)
                    begin
                        drop_branches();
                        rom_image = '0;
                        st = ST_NO_PRESENCE;
                    end
                    else
                        st = ST_STARTED;
                    close_pass();
                    in_pass = (st == ST_STARTED);
                end
                OP_PAIR:
                begin
                    if (in_pass && idb && cmpb)
                    begin
                        drop_branches();
                        close_pass();
                        st = ST_FAILED;
                    end
                    else if (in_pass)
                    begin
                        idx = int'(cur_pos) - 1;
                        if (idb != cmpb)
                            dir = idb;
                        else
                        begin
                            // Both branches exist: repeat the old path below the last
                            // discrepancy, take one at it and zero beyond it.
                            if (cur_pos < prev_branch)
                                dir = rom_image[idx];
                            else
                                dir = (cur_pos == prev_branch);
                            if (!dir)
                            begin
                                new_branch = cur_pos;
                                if (cur_pos < FAMILY_LIMIT)
                                    family_branch = cur_pos[FAM_WIDTH-1:0];
                            end
                        end
                        rom_image[idx] = dir;
                        if (cur_pos + 7'd1 == END_POSITION)
                        begin
                            prev_branch = new_branch;
                            if (prev_branch == '0)
                                last_found = 1'b1;
                            if (rom_image[7:0] == 8'd0)
                            begin
                                drop_branches();
                                st  = ST_FAILED;
                                dir = 1'b0;
                            end
                            else
                                st = ST_FOUND;
                            close_pass();
                        end
                        else
                        begin
                            cur_pos = cur_pos + 7'd1;
                            st = ST_BIT_DONE;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    drop_branches();
                    rom_image = '0;
                    close_pass();
                end
                default:
                begin
                end
            endcase
            res.status             = st;
            res.write_bit          = dir;
            res.rom_code           = rom_image;
            res.last_device        = last_found;
            res.family_discrepancy = family_branch;
            owed_results.push_back(res);
            return res;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(osr_rsp_t got);
            osr_rsp_t want;
            if (owed_results.size() == 0)
                report("result arrived with none outstanding");
            else
            begin
                want = owed_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
                if (got.write_bit !== want.write_bit)
                    report($sformatf("write_bit %b, expected %b", got.write_bit,
                        want.write_bit));
                if (got.rom_code !== want.rom_code)
                    report($sformatf("rom_code %h, expected %h", got.rom_code,
                        want.rom_code));
                if (got.last_device !== want.last_device)
                    report($sformatf("last_device %b, expected %b", got.last_device,
                        want.last_device));
                if (got.family_discrepancy !== want.family_discrepancy)
                    report($sformatf("family_discrepancy %0d, expected %0d",
                        got.family_discrepancy, want.family_discrepancy));
            end
        endtask

        function int pending();
            return owed_results.size();
        endfunction

        task report_leftovers();
            if (owed_results.size() != 0)
                report($sformatf("%0d results never arrived", owed_results.size()));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode = OP_START;
    logic                 presence = 1'b0;
    logic                 id_bit = 1'b0;
    logic                 complement_bit = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           status;
    logic                 write_bit;
    logic [ROM_WIDTH-1:0] rom_code;
    logic                 last_device;
    logic [FAM_WIDTH-1:0] family_discrepancy;

    search_scoreboard board;
    osr_rsp_t         seen_result;
    int               send_idle_pct = 24;
    int               recv_idle_pct = 88;
    int               item_count = 0;
    int               stall_count = 0;

    one_wire_rom_search_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .presence           (presence),
        .id_bit             (id_bit),
        .complement_bit     (complement_bit),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .write_bit          (write_bit),
        .rom_code           (rom_code),
        .last_device        (last_device),
        .family_discrepancy (family_discrepancy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offers one request, holds it until taken and returns the result it should cause.
    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input logic [1:0] op, input logic pres, input logic idb,
                                input logic cmpb, output osr_rsp_t pred);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        presence       <= pres;
        id_bit         <= idb;
        complement_bit <= cmpb;
        do
            @(posedge clk);
        while (!in_ready);
        pred = board.note_request(op, pres, idb, cmpb);
        item_count++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        osr_rsp_t pred;
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b1, pred);
        send_request(OP_UNUSED, 1'b1, 1'b1, 1'b1, pred);
        send_request(OP_CLEAR, 1'b0, 1'b0, 1'b0, pred);
        send_request(OP_START, 1'b0, 1'b1, 1'b1, pred);
        send_request(OP_START, 1'b1, 1'b0, 1'b0, pred);
        send_request(OP_PAIR, 1'b0, 1'b1, 1'b0, pred);
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b1, pred);
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b0, pred);
        send_request(OP_PAIR, 1'b1, 1'b1, 1'b1, pred);
        send_request(OP_PAIR, 1'b0, 1'b0, 1'b0, pred);
        send_request(OP_START, 1'b1, 1'b1, 1'b1, pred);
        send_request(OP_PAIR, 1'b1, 1'b0, 1'b0, pred);
        send_request(OP_START, 1'b1, 1'b0, 1'b1, pred);
        send_request(OP_PAIR, 1'b0, 1'b1, 1'b0, pred);
        send_request(OP_CLEAR, 1'b1, 1'b1, 1'b1, pred);
        send_request(OP_PAIR, 1'b0, 1'b1, 1'b0, pred);
        send_request(OP_UNUSED, 1'b0, 1'b0, 1'b1, pred);
    endtask

    // Enumerates a simulated bus of a few devices. The bus answers each bit slot with the
    // wired AND of the devices still selected, so both branches appear where codes differ.
    task automatic run_enumeration();
        logic [ROM_WIDTH-1:0] dev_rom [MAX_DEVICES];
        bit                   dev_on [MAX_DEVICES];
        int                   ndev;
        int                   pass_no;
        int                   b;
        int                   i;
        int                   pick;
        logic                 idb;
        logic                 cmpb;
        bit                   pass_over;
        osr_rsp_t             pred;
        ndev = $urandom_range(1, MAX_DEVICES);
        for (i = 0; i < ndev; i++)
        begin
            case ($urandom_range(15))
                0: dev_rom[i] = '1;
                1: dev_rom[i] = 64'h1;
                2: dev_rom[i] = 64'h8000_0000_0000_0000;
                default: dev_rom[i] = {$urandom, $urandom};
            endcase
            // Near copies of an earlier code give discrepancies deep in the tree or
            // within the family byte.
            if (i > 0 && $urandom_range(1) == 0)
            begin
                dev_rom[i] = dev_rom[$urandom_range(i - 1)];
                dev_rom[i][$urandom_range(ROM_WIDTH - 1)] ^= 1'b1;
            end
            if ($urandom_range(9) == 0)
                dev_rom[i][7:0] = 8'd0;
        end
        for (pass_no = 0; pass_no < ndev + 3 && item_count < TOTAL_ITEMS; pass_no++)
        begin
            if ($urandom_range(29) == 0)
                send_request(OP_START, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    pred);
            send_request(OP_START, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), pred);
            if (pred.status == ST_NO_MORE)
                break;
            for (i = 0; i < ndev; i++)
                dev_on[i] = 1'b1;
            pass_over = 1'b0;
            for (b = 0; b < ROM_WIDTH && !pass_over; b++)
            begin
                idb  = 1'b1;
                cmpb = 1'b1;
                for (i = 0; i < ndev; i++)
                    if (dev_on[i])
                    begin
                        idb  &= dev_rom[i][b];
                        cmpb &= ~dev_rom[i][b];
                    end
                pick = $urandom_range(999);
                if (pick == 0)
                begin
                    idb  = 1'b1;
                    cmpb = 1'b1;
                end
                else if (pick == 1)
                begin
                    idb  = 1'($urandom_range(1));
                    cmpb = 1'($urandom_range(1));
                end
                if (pick == 2)
                begin
                    send_request(OP_CLEAR, 1'($urandom_range(1)), idb, cmpb, pred);
                    pass_over = 1'b1;
                end
                else
                begin
                    send_request(OP_PAIR, 1'($urandom_range(1)), idb, cmpb, pred);
                    pass_over = (pred.status != ST_BIT_DONE);
                    for (i = 0; i < ndev; i++)
                        if (dev_rom[i][b] != pred.write_bit)
                            dev_on[i] = 1'b0;
                end
            end
        end
    endtask

    task automatic run_noise();
        osr_rsp_t pred;
        int n;
        for (n = $urandom_range(1, 6); n > 0; n--)
            send_request(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), pred);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            seen_result.status             = status;
            seen_result.write_bit          = write_bit;
            seen_result.rom_code           = rom_code;
            seen_result.last_device        = last_device;
            seen_result.family_discrepancy = family_discrepancy;
            board.check_result(seen_result);
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends a hung run: no request and no result moving for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int next_phase;
        osr_rsp_t pred;
        board = new();
        phase = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (item_count < TOTAL_ITEMS)
        begin
            next_phase = (item_count * 3) / TOTAL_ITEMS;
            if (next_phase > 2)
                next_phase = 2;
            if (next_phase != phase)
            begin
                // Hold the sender back until every owed result has come out.
                wait_for_drain();
                phase = next_phase;
                send_idle_pct = (phase == 1) ? 88 : 0;
                recv_idle_pct = (phase == 1) ? 24 : 0;
            end
            case ($urandom_range(9))
                0: send_request(OP_START, 1'b0, 1'($urandom_range(1)),
                    1'($urandom_range(1)), pred);
                1: run_noise();
                default: run_enumeration();
            endcase
        end
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.report_leftovers();
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
